// ===== rtl/core/sms_cmt_header_parser_defines.svh =====
// Assertion macros shared by the modem header parser RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef SMS_CMT_HEADER_PARSER_DEFINES_SVH
`define SMS_CMT_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SMS_CMT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMS_CMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sms_cmt_pkg.sv =====
// Shared types, character codes and lookup functions for the modem header parser.
// No dependencies.
package sms_cmt_pkg;

	localparam int SENDER_MAX_DEF = 32;
	localparam int STAMP_MAX_DEF  = 32;
	localparam int TOKEN_MAX_DEF  = 7;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] PREFIX_LAST   = 3'd3;
	localparam logic [2:0] PREFIX_LEN    = 3'd4;
	localparam logic [2:0] SENDER_QUOTE  = 3'd1;
	localparam logic [2:0] STAMP_QUOTE   = 3'd5;
	localparam logic [2:0] QUOTES_TOTAL  = 3'd6;
	localparam logic [2:0] FIELDS_TOTAL  = 3'd6;
	localparam logic [5:0] COUNT_SAT     = 6'd63;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_PREFIX,
		PH_NOCMT,
		PH_FIELDS
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_CMT    = 3'd1,
		ST_NO_QUOTE  = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_MALFORMED = 3'd4
	} status_t;

	typedef struct packed {
		logic       step;
		logic       close;
		logic       clear;
		logic [7:0] ch;
	} stamp_ctrl_t;

	typedef struct packed {
		logic [15:0]     year;
		logic [4:0][7:0] date;
		logic [5:0]      valid;
		status_t         status;
	} stamp_view_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  sender_char;
		status_t     status;
		logic [5:0]  sender_len;
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [5:0]  field_ok;
	} result_t;

	// "+CMT", one character per prefix position
	function automatic logic [7:0] cmt_char(input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0: c = 8'h2B;
			2'd1: c = 8'h43;
			2'd2: c = 8'h4D;
			default: c = 8'h54;
		endcase
		return c;
	endfunction

	// delimiter that closes each timestamp token
	function automatic logic [7:0] stamp_delim(input logic [2:0] sel);
		logic [7:0] c;
		case (sel)
			3'd0, 3'd1: c = 8'h2F;
			3'd2:       c = 8'h2C;
			3'd3, 3'd4: c = 8'h3A;
			default:    c = 8'h2B;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/sms_cmt_stamp.sv =====
// Timestamp token parser: splits yy/mm/dd,hh:mm:ss into six fields with valid bits.
// Depends on sms_cmt_pkg. The view output shows the state after the current request.
module sms_cmt_stamp #(
	parameter int STAMP_MAX = sms_cmt_pkg::STAMP_MAX_DEF,
	parameter int TOKEN_MAX = sms_cmt_pkg::TOKEN_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sms_cmt_pkg::stamp_ctrl_t  ctrl,
	output sms_cmt_pkg::stamp_view_t  view
);

	logic [5:0]           stamp_count_q, stamp_count_nx;
	logic [15:0]          token_value_q, token_value_nx;
	logic [2:0]           token_len_q, token_len_nx;
	logic                 digits_only_q, digits_only_nx;
	logic [2:0]           field_sel_q, field_sel_nx;
	logic [15:0]          year_q, year_nx;
	logic [4:0][7:0]      date_q, date_nx;
	logic [5:0]           valid_q, valid_nx;
	sms_cmt_pkg::status_t status_q, status_nx;
	logic [2:0]           date_idx;
	logic                 is_digit;

	assign date_idx = field_sel_q - 3'd1;
	assign is_digit = (ctrl.ch >= sms_cmt_pkg::CH_ZERO) && (ctrl.ch <= sms_cmt_pkg::CH_NINE);

	always_comb begin
		stamp_count_nx = stamp_count_q;
		token_value_nx = token_value_q;
		token_len_nx   = token_len_q;
		digits_only_nx = digits_only_q;
		field_sel_nx   = field_sel_q;
		year_nx        = year_q;
		date_nx        = date_q;
		valid_nx       = valid_q;
		status_nx      = status_q;
		if (ctrl.step) begin
			if (stamp_count_q != sms_cmt_pkg::COUNT_SAT) begin
				stamp_count_nx = stamp_count_q + 6'd1;
			end
			if (field_sel_q < sms_cmt_pkg::FIELDS_TOTAL
					&& status_q != sms_cmt_pkg::ST_MALFORMED) begin
				if (ctrl.ch == sms_cmt_pkg::stamp_delim(field_sel_q) && token_len_q != 3'd0) begin
					// commit the token; a token with a non-digit leaves its field alone
					if (digits_only_q) begin
						if (field_sel_q == 3'd0) begin
							year_nx = token_value_q;
						end else begin
							date_nx[date_idx] = token_value_q[7:0];
						end
						valid_nx[field_sel_q] = 1'b1;
					end
					field_sel_nx   = field_sel_q + 3'd1;
					token_value_nx = '0;
					token_len_nx   = '0;
					digits_only_nx = 1'b1;
				end else if (token_len_q >= 3'(TOKEN_MAX)) begin
					status_nx = sms_cmt_pkg::ST_MALFORMED;
				end else begin
					token_len_nx = token_len_q + 3'd1;
					if (is_digit) begin
						token_value_nx = (token_value_q << 3) + (token_value_q << 1)
							+ {12'd0, ctrl.ch[3:0]};
					end else begin
						digits_only_nx = 1'b0;
					end
				end
			end
		end
		if (ctrl.close) begin
			if (stamp_count_q >= 6'(STAMP_MAX)) begin
				status_nx = sms_cmt_pkg::ST_TOO_LONG;
			end else if (field_sel_q < sms_cmt_pkg::FIELDS_TOTAL) begin
				status_nx = sms_cmt_pkg::ST_MALFORMED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_count_q <= '0;
			token_value_q <= '0;
			token_len_q   <= '0;
			digits_only_q <= 1'b1;
			field_sel_q   <= '0;
			year_q        <= '0;
			date_q        <= '0;
			valid_q       <= '0;
			status_q      <= sms_cmt_pkg::ST_OK;
		end else if (ctrl.clear) begin
			stamp_count_q <= '0;
			token_value_q <= '0;
			token_len_q   <= '0;
			digits_only_q <= 1'b1;
			field_sel_q   <= '0;
			year_q        <= '0;
			date_q        <= '0;
			valid_q       <= '0;
			status_q      <= sms_cmt_pkg::ST_OK;
		end else begin
			stamp_count_q <= stamp_count_nx;
			token_value_q <= token_value_nx;
			token_len_q   <= token_len_nx;
			digits_only_q <= digits_only_nx;
			field_sel_q   <= field_sel_nx;
			year_q        <= year_nx;
			date_q        <= date_nx;
			valid_q       <= valid_nx;
			status_q      <= status_nx;
		end
	end

	assign view.year   = year_nx;
	assign view.date   = date_nx;
	assign view.valid  = valid_nx;
	assign view.status = status_nx;

endmodule

// ===== rtl/core/sms_cmt_outreg.sv =====
// Result register of the modem header parser: holds one result until it is taken.
// Depends on sms_cmt_pkg.
module sms_cmt_outreg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  sms_cmt_pkg::result_t load_res,
	input  logic                 ready,
	output logic                 valid,
	output logic                 free,
	output sms_cmt_pkg::result_t res
);

	logic                 valid_q;
	sms_cmt_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
	end

	assign valid = valid_q;
	assign free  = !valid_q || ready;
	assign res   = res_q;

endmodule

// ===== rtl/core/sms_cmt_header_parser.sv =====
// Parser for the "+CMT" header line of a text-mode SMS, one byte per request. A byte
// enters an input register and is parsed from there into a single result
// register, so the block takes one byte every clock cycle as long as results are
// taken. The result register loads its result when the byte leaves the input
// register. Sender bytes come out as they arrive; the byte marked last yields an
// end-of-line summary and re-arms the parser for the next line. A byte that gives
// no result moves on even while the result register is full; only a byte that
// gives a result waits for it to drain.
`include "sms_cmt_header_parser_defines.svh"

module sms_cmt_header_parser #(
	parameter int SENDER_MAX = sms_cmt_pkg::SENDER_MAX_DEF,
	parameter int STAMP_MAX  = sms_cmt_pkg::STAMP_MAX_DEF,
	parameter int TOKEN_MAX  = sms_cmt_pkg::TOKEN_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  sender_char,
	output logic [2:0]  status,
	output logic [5:0]  sender_len,
	output logic [15:0] year,
	output logic [7:0]  month,
	output logic [7:0]  day,
	output logic [7:0]  hour,
	output logic [7:0]  minute,
	output logic [7:0]  second,
	output logic [5:0]  field_ok
);

	logic                     valid_s1;
	logic [7:0]               data_s1;
	logic                     last_s1;

	sms_cmt_pkg::phase_t      phase_q, phase_nx, ph_eff;
	logic [2:0]               prefix_pos_q, prefix_pos_nx;
	logic [2:0]               quote_count_q, quote_count_nx;
	logic [5:0]               sender_count_q, sender_count_nx;

	logic                     is_ws;
	logic                     in_fields;
	logic                     quote_evt;
	logic                     sender_evt;
	logic                     emit_char;
	logic                     produces;
	logic                     adv;
	logic                     out_free;
	sms_cmt_pkg::status_t     st;
	sms_cmt_pkg::stamp_ctrl_t stamp_ctrl;
	sms_cmt_pkg::stamp_view_t stamp_view;
	sms_cmt_pkg::result_t     res_nx;
	sms_cmt_pkg::result_t     res_q;

	// input register
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	// leave skipping on the first non-blank byte, which is already a prefix byte
	assign is_ws = (data_s1 == sms_cmt_pkg::CH_CR) || (data_s1 == sms_cmt_pkg::CH_LF)
		|| (data_s1 == sms_cmt_pkg::CH_SPACE);
	assign ph_eff = (phase_q == sms_cmt_pkg::PH_SKIP && !is_ws) ? sms_cmt_pkg::PH_PREFIX
		: phase_q;

	// next state of the line phase
	always_comb begin
		phase_nx      = ph_eff;
		prefix_pos_nx = prefix_pos_q;
		if (ph_eff == sms_cmt_pkg::PH_PREFIX) begin
			if (data_s1 == sms_cmt_pkg::cmt_char(prefix_pos_q[1:0])) begin
				prefix_pos_nx = prefix_pos_q + 3'd1;
				if (prefix_pos_q == sms_cmt_pkg::PREFIX_LAST) begin
					phase_nx = sms_cmt_pkg::PH_FIELDS;
				end
			end else begin
				phase_nx = sms_cmt_pkg::PH_NOCMT;
			end
		end
	end

	// field counters, timestamp control and result
	assign in_fields  = (ph_eff == sms_cmt_pkg::PH_FIELDS);
	assign quote_evt  = in_fields && data_s1 == sms_cmt_pkg::CH_QUOTE
		&& quote_count_q < sms_cmt_pkg::QUOTES_TOTAL;
	assign sender_evt = in_fields && !quote_evt && quote_count_q == sms_cmt_pkg::SENDER_QUOTE;
	assign emit_char  = sender_evt && !last_s1 && sender_count_q < 6'(SENDER_MAX - 1);
	assign produces   = emit_char || last_s1;
	assign adv        = valid_s1 && (!produces || out_free);

	assign stamp_ctrl.step  = adv && in_fields && !quote_evt
		&& quote_count_q == sms_cmt_pkg::STAMP_QUOTE;
	assign stamp_ctrl.close = adv && quote_evt && quote_count_q == sms_cmt_pkg::STAMP_QUOTE;
	assign stamp_ctrl.clear = adv && last_s1;
	assign stamp_ctrl.ch    = data_s1;

	always_comb begin
		quote_count_nx  = quote_count_q;
		sender_count_nx = sender_count_q;
		if (quote_evt) begin
			quote_count_nx = quote_count_q + 3'd1;
		end
		if (sender_evt && sender_count_q != sms_cmt_pkg::COUNT_SAT) begin
			sender_count_nx = sender_count_q + 6'd1;
		end

		if (phase_nx != sms_cmt_pkg::PH_FIELDS) begin
			st = sms_cmt_pkg::ST_NO_CMT;
		end else if (quote_count_nx < sms_cmt_pkg::QUOTES_TOTAL) begin
			st = sms_cmt_pkg::ST_NO_QUOTE;
		end else begin
			st = stamp_view.status;
		end

		res_nx = '0;
		if (last_s1) begin
			res_nx.kind       = 1'b1;
			res_nx.status     = st;
			res_nx.sender_len = sender_count_nx;
			if (st == sms_cmt_pkg::ST_OK || st == sms_cmt_pkg::ST_MALFORMED) begin
				res_nx.year     = stamp_view.year;
				res_nx.month    = stamp_view.date[0];
				res_nx.day      = stamp_view.date[1];
				res_nx.hour     = stamp_view.date[2];
				res_nx.minute   = stamp_view.date[3];
				res_nx.second   = stamp_view.date[4];
				res_nx.field_ok = stamp_view.valid;
			end
		end else begin
			res_nx.status      = sms_cmt_pkg::ST_OK;
			res_nx.sender_char = data_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= sms_cmt_pkg::PH_SKIP;
			prefix_pos_q   <= '0;
			quote_count_q  <= '0;
			sender_count_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				phase_q        <= sms_cmt_pkg::PH_SKIP;
				prefix_pos_q   <= '0;
				quote_count_q  <= '0;
				sender_count_q <= '0;
			end else begin
				phase_q        <= phase_nx;
				prefix_pos_q   <= prefix_pos_nx;
				quote_count_q  <= quote_count_nx;
				sender_count_q <= sender_count_nx;
			end
		end
	end

	sms_cmt_stamp #(
		.STAMP_MAX (STAMP_MAX),
		.TOKEN_MAX (TOKEN_MAX)
	) u_stamp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (stamp_ctrl),
		.view   (stamp_view)
	);

	sms_cmt_outreg u_outreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv && produces),
		.load_res (res_nx),
		.ready    (out_ready),
		.valid    (out_valid),
		.free     (out_free),
		.res      (res_q)
	);

	assign kind        = res_q.kind;
	assign sender_char = res_q.sender_char;
	assign status      = res_q.status;
	assign sender_len  = res_q.sender_len;
	assign year        = res_q.year;
	assign month       = res_q.month;
	assign day         = res_q.day;
	assign hour        = res_q.hour;
	assign minute      = res_q.minute;
	assign second      = res_q.second;
	assign field_ok    = res_q.field_ok;

	`SMS_CMT_ASSERT_SAME(a_char_clean, out_valid && !kind,
		status == sms_cmt_pkg::ST_OK && sender_len == 6'd0 && field_ok == 6'd0,
		"sender byte result carries summary fields")
	`SMS_CMT_ASSERT_SAME(a_fail_no_date, out_valid && kind
		&& (status == sms_cmt_pkg::ST_NO_CMT || status == sms_cmt_pkg::ST_NO_QUOTE
		|| status == sms_cmt_pkg::ST_TOO_LONG), field_ok == 6'd0 && year == 16'd0,
		"failed summary reports a date")
	`SMS_CMT_ASSERT_NEXT(a_line_rearm, adv && last_s1,
		phase_q == sms_cmt_pkg::PH_SKIP && quote_count_q == 3'd0 && sender_count_q == 6'd0,
		"parser not re-armed after end of line")
	`SMS_CMT_ASSERT_SAME(a_prefix_done, phase_q == sms_cmt_pkg::PH_FIELDS,
		prefix_pos_q == sms_cmt_pkg::PREFIX_LEN,
		"field phase entered without full prefix")

endmodule
